[rtl/iafp_pkg.sv]
package iafp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned NumStored = 7;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [ByteW-1:0] HeaderReset    = 8'h55;
  localparam logic [ByteW-1:0] AngleTypeReset = 8'h53;
  localparam logic signed [8:0] ScaleFactor   = 9'sd180;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER     = 2'd0,
    REG_ANGLE_TYPE = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] header;
    logic [ByteW-1:0] angle_type;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [AngleW-1:0] roll_word;
    logic [AngleW-1:0] pitch_word;
    logic [AngleW-1:0] yaw_word;
  } frame_t;

  function automatic logic signed [AngleW-1:0] scale_angle(input logic [AngleW-1:0] word);
    logic signed [24:0] prod;
    prod = $signed(word) * ScaleFactor;
    return prod[23:8];
  endfunction

endpackage

[rtl/iafp_cfg_regs.sv]
module iafp_cfg_regs
  import iafp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HEADER:     cfg_d.header     = cfg_data_i;
        REG_ANGLE_TYPE: cfg_d.angle_type = cfg_data_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header     <= HeaderReset;
      cfg_q.angle_type <= AngleTypeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/iafp_collector.sv]
module iafp_collector
  import iafp_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  input  logic             res_ready_i,
  output frame_t           frame_o
);

  localparam int unsigned PosW = $clog2(FRAME_LENGTH);

  logic             a_valid_q, a_valid_d;
  logic [ByteW-1:0] a_byte_q, a_byte_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] bytes_q [NumStored];
  logic [ByteW-1:0] view    [NumStored];
  logic [PosW:0]    pos_inc;
  logic             adv;
  logic             done;

  assign in_stall_o = a_valid_q && !res_ready_i;
  assign adv        = a_valid_q && res_ready_i;
  assign a_valid_d  = in_stall_o ? a_valid_q : in_valid_i;
  assign a_byte_d   = in_stall_o ? a_byte_q : rx_byte_i;
  assign pos_inc    = {1'b0, pos_q} + (PosW+1)'(1);

  always_comb begin
    for (int k = 0; k < NumStored; k++) begin
      view[k] = (pos_q == PosW'(k + 1)) ? a_byte_q : bytes_q[k];
    end
  end

  always_comb begin
    pos_d = pos_q;
    done  = 1'b0;
    if (adv) begin
      if (pos_q == '0) begin
        if (a_byte_q == cfg_i.header) begin
          pos_d = PosW'(1);
        end
      end else if (pos_inc >= (PosW+1)'(FRAME_LENGTH)) begin
        pos_d = '0;
        done  = 1'b1;
      end else begin
        pos_d = pos_inc[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_byte_q <= a_byte_d;
    for (int k = 0; k < NumStored; k++) begin
      if (adv && pos_q == PosW'(k + 1)) begin
        bytes_q[k] <= a_byte_q;
      end
    end
  end

  assign frame_o.hit        = done && (view[0] == cfg_i.angle_type);
  assign frame_o.roll_word  = {view[2], view[1]};
  assign frame_o.pitch_word = {view[4], view[3]};
  assign frame_o.yaw_word   = {view[6], view[5]};

endmodule

[rtl/iafp_result_reg.sv]
module iafp_result_reg
  import iafp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  frame_t                   frame_i,
  output logic                     res_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [AngleW-1:0] roll_angle_o,
  output logic signed [AngleW-1:0] pitch_angle_o,
  output logic signed [AngleW-1:0] yaw_angle_o
);

  logic                     valid_q, valid_d;
  logic signed [AngleW-1:0] roll_q, pitch_q, yaw_q;

  assign res_ready_o = !valid_q || !out_stall_i;
  assign valid_d     = res_ready_o ? frame_i.hit : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && frame_i.hit) begin
      roll_q  <= scale_angle(frame_i.roll_word);
      pitch_q <= scale_angle(frame_i.pitch_word);
      yaw_q   <= scale_angle(frame_i.yaw_word);
    end
  end

  assign out_valid_o   = valid_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

endmodule

[rtl/imu_angle_frame_parser.sv]
// Angle frame parser for an inertial sensor's serial byte stream.
// Input channel: one received byte per transaction on in_valid_i/rx_byte_i,
// held off by in_stall_o. Bytes outside a frame are dropped until the
// header byte is seen; the next FRAME_LENGTH-1 bytes complete the frame.
// Output channel: one transaction with roll, pitch and yaw (signed degrees,
// 7 fractional bits) per completed frame whose type byte matches; other
// frames give nothing. out_stall_i holds the result in place.
// Configuration: cfg_valid_i/cfg_index_i/cfg_data_i write the header byte
// (index 0) and the angle type byte (index 1); cfg_ready_o is always high.
// Throughput: one byte per cycle while in_stall_o is low. The byte is
// registered in the input register on acceptance, and the angles are computed
// from it into the output register, which raises out_valid_o for a matching frame.
// While a result is stalled, one more byte is taken into the input register
// if it is empty, then in_stall_o rises until the result is taken.
// Reset clears the frame position (hunting for header), both valid flags,
// and loads the registers with 0x55 and 0x53.
module imu_angle_frame_parser
  import iafp_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ByteW-1:0]         rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [AngleW-1:0] roll_angle_o,
  output logic signed [AngleW-1:0] pitch_angle_o,
  output logic signed [AngleW-1:0] yaw_angle_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [ByteW-1:0]         cfg_data_i
);

  cfg_t   cfg;
  frame_t frame;
  logic   res_ready;

  iafp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  iafp_collector #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_collector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .res_ready_i (res_ready),
    .frame_o     (frame)
  );

  iafp_result_reg u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame),
    .res_ready_o   (res_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .roll_angle_o  (roll_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .yaw_angle_o   (yaw_angle_o)
  );

endmodule
